[src/sfs_pkg.sv]
package sfs_pkg;

    localparam int FRAME_DEPTH = 64;
    localparam int TIME_BITS   = 24;
    localparam int COORD_BITS  = 16;

    localparam int ADDR_W     = (FRAME_DEPTH > 1) ? $clog2(FRAME_DEPTH) : 1;
    localparam int CNT_W      = $clog2(FRAME_DEPTH + 1);
    localparam int IDX_W      = 7;
    localparam int SEEK_W     = 6;
    localparam int OPC_W      = 3;
    localparam int ERR_W      = 2;
    localparam int UPC_W      = 5;
    localparam int DIV_CNT_W  = $clog2(TIME_BITS + 2);
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = (TIME_BITS > COORD_BITS) ? TIME_BITS : COORD_BITS;

    localparam logic [TIME_BITS-1:0] FRAME_TIME_RESET = TIME_BITS'(100000);

    localparam logic [OPC_W-1:0] OP_TICK   = 3'd0;
    localparam logic [OPC_W-1:0] OP_APPEND = 3'd1;
    localparam logic [OPC_W-1:0] OP_PLAY   = 3'd2;
    localparam logic [OPC_W-1:0] OP_STOP   = 3'd3;
    localparam logic [OPC_W-1:0] OP_SEEK   = 3'd4;

    localparam logic [ERR_W-1:0] ERR_OK         = 2'd0;
    localparam logic [ERR_W-1:0] ERR_TABLE_FULL = 2'd1;
    localparam logic [ERR_W-1:0] ERR_SEEK_RANGE = 2'd2;
    localparam logic [ERR_W-1:0] ERR_NO_FRAMES  = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_TIME   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOOP_ENABLE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd3;

    typedef struct packed {
        logic [OPC_W-1:0]      opcode;
        logic [TIME_BITS-1:0]  elapsed_us;
        logic [COORD_BITS-1:0] new_x;
        logic [COORD_BITS-1:0] new_y;
        logic                  restart;
        logic [SEEK_W-1:0]     seek_index;
    } t_in_item;

    typedef struct packed {
        logic [COORD_BITS-1:0] rect_x;
        logic [COORD_BITS-1:0] rect_y;
        logic [COORD_BITS-1:0] rect_w;
        logic [COORD_BITS-1:0] rect_h;
        logic                  rect_updated;
        logic [IDX_W-1:0]      current_index;
        logic                  is_playing;
        logic [ERR_W-1:0]      error_code;
    } t_out_item;

    typedef struct packed {
        logic [TIME_BITS-1:0]  frame_time_us;
        logic                  loop_enable;
        logic [COORD_BITS-1:0] frame_width;
        logic [COORD_BITS-1:0] frame_height;
    } t_cfg;

    typedef enum logic [3:0] {
        A_NONE,
        A_ACCEPT,
        A_PLAY,
        A_STOP,
        A_SEEK,
        A_ERR_SEEK,
        A_APPEND,
        A_ERR_FULL,
        A_ERR_NOFR,
        A_SUM,
        A_KEEP_SUM,
        A_DIV_INIT,
        A_DIV_STEP,
        A_ADVANCE,
        A_SHOW,
        A_EMIT
    } t_act;

    typedef enum logic [3:0] {
        J_NEVER,
        J_ALWAYS,
        J_NO_ITEM,
        J_OP_TICK,
        J_OP_APPEND,
        J_OP_PLAY,
        J_OP_STOP,
        J_OP_SEEK,
        J_SEEK_BAD,
        J_FULL,
        J_NOT_RUNNING,
        J_HAVE_FRAMES,
        J_SUM_GE_FT,
        J_DIV_BUSY,
        J_END_NO_LOOP,
        J_OUT_BUSY
    } t_jcond;

    typedef struct packed {
        t_act             act;
        t_jcond           jcond;
        logic [UPC_W-1:0] target;
    } t_uop;

    typedef struct packed {
        logic item_valid;
        logic op_tick;
        logic op_append;
        logic op_play;
        logic op_stop;
        logic op_seek;
        logic seek_bad;
        logic full;
        logic running;
        logic have_frames;
        logic sum_ge_ft;
        logic div_busy;
        logic end_no_loop;
        logic out_busy;
    } t_cond;

    localparam logic [UPC_W-1:0] U_IDLE      = 5'd0;
    localparam logic [UPC_W-1:0] U_DISP_TICK = 5'd1;
    localparam logic [UPC_W-1:0] U_DISP_APP  = 5'd2;
    localparam logic [UPC_W-1:0] U_DISP_PLAY = 5'd3;
    localparam logic [UPC_W-1:0] U_DISP_STOP = 5'd4;
    localparam logic [UPC_W-1:0] U_DISP_SEEK = 5'd5;
    localparam logic [UPC_W-1:0] U_DISP_NOP  = 5'd6;
    localparam logic [UPC_W-1:0] U_PLAY      = 5'd7;
    localparam logic [UPC_W-1:0] U_STOP      = 5'd8;
    localparam logic [UPC_W-1:0] U_SEEK      = 5'd9;
    localparam logic [UPC_W-1:0] U_SEEK_SET  = 5'd10;
    localparam logic [UPC_W-1:0] U_SEEK_ERR  = 5'd11;
    localparam logic [UPC_W-1:0] U_APPEND    = 5'd12;
    localparam logic [UPC_W-1:0] U_APP_WRITE = 5'd13;
    localparam logic [UPC_W-1:0] U_APP_ERR   = 5'd14;
    localparam logic [UPC_W-1:0] U_TICK      = 5'd15;
    localparam logic [UPC_W-1:0] U_TICK_CNT  = 5'd16;
    localparam logic [UPC_W-1:0] U_TICK_ERR  = 5'd17;
    localparam logic [UPC_W-1:0] U_TICK_SUM  = 5'd18;
    localparam logic [UPC_W-1:0] U_TICK_CMP  = 5'd19;
    localparam logic [UPC_W-1:0] U_TICK_KEEP = 5'd20;
    localparam logic [UPC_W-1:0] U_DIV       = 5'd21;
    localparam logic [UPC_W-1:0] U_ADVANCE   = 5'd22;
    localparam logic [UPC_W-1:0] U_LOAD      = 5'd23;
    localparam logic [UPC_W-1:0] U_SHOW      = 5'd24;
    localparam logic [UPC_W-1:0] U_EMIT      = 5'd25;
    localparam logic [UPC_W-1:0] U_RETURN    = 5'd26;

    function automatic t_uop uw(input t_act act, input t_jcond jc, input logic [UPC_W-1:0] tg);
        t_uop w;
        w.act    = act;
        w.jcond  = jc;
        w.target = tg;
        return w;
    endfunction

    function automatic t_uop ucode_word(input logic [UPC_W-1:0] upc);
        t_uop w;
        unique case (upc)
            U_IDLE:      w = uw(A_ACCEPT,   J_NO_ITEM,     U_IDLE);
            U_DISP_TICK: w = uw(A_NONE,     J_OP_TICK,     U_TICK);
            U_DISP_APP:  w = uw(A_NONE,     J_OP_APPEND,   U_APPEND);
            U_DISP_PLAY: w = uw(A_NONE,     J_OP_PLAY,     U_PLAY);
            U_DISP_STOP: w = uw(A_NONE,     J_OP_STOP,     U_STOP);
            U_DISP_SEEK: w = uw(A_NONE,     J_OP_SEEK,     U_SEEK);
            U_DISP_NOP:  w = uw(A_NONE,     J_ALWAYS,      U_EMIT);
            U_PLAY:      w = uw(A_PLAY,     J_ALWAYS,      U_EMIT);
            U_STOP:      w = uw(A_STOP,     J_ALWAYS,      U_EMIT);
            U_SEEK:      w = uw(A_NONE,     J_SEEK_BAD,    U_SEEK_ERR);
            U_SEEK_SET:  w = uw(A_SEEK,     J_ALWAYS,      U_LOAD);
            U_SEEK_ERR:  w = uw(A_ERR_SEEK, J_ALWAYS,      U_EMIT);
            U_APPEND:    w = uw(A_NONE,     J_FULL,        U_APP_ERR);
            U_APP_WRITE: w = uw(A_APPEND,   J_ALWAYS,      U_LOAD);
            U_APP_ERR:   w = uw(A_ERR_FULL, J_ALWAYS,      U_EMIT);
            U_TICK:      w = uw(A_NONE,     J_NOT_RUNNING, U_EMIT);
            U_TICK_CNT:  w = uw(A_NONE,     J_HAVE_FRAMES, U_TICK_SUM);
            U_TICK_ERR:  w = uw(A_ERR_NOFR, J_ALWAYS,      U_EMIT);
            U_TICK_SUM:  w = uw(A_SUM,      J_NEVER,       U_IDLE);
            U_TICK_CMP:  w = uw(A_DIV_INIT, J_SUM_GE_FT,   U_DIV);
            U_TICK_KEEP: w = uw(A_KEEP_SUM, J_ALWAYS,      U_EMIT);
            U_DIV:       w = uw(A_DIV_STEP, J_DIV_BUSY,    U_DIV);
            U_ADVANCE:   w = uw(A_ADVANCE,  J_END_NO_LOOP, U_EMIT);
            U_LOAD:      w = uw(A_NONE,     J_NEVER,       U_IDLE);
            U_SHOW:      w = uw(A_SHOW,     J_NEVER,       U_IDLE);
            U_EMIT:      w = uw(A_EMIT,     J_OUT_BUSY,    U_EMIT);
            U_RETURN:    w = uw(A_NONE,     J_ALWAYS,      U_IDLE);
            default:     w = uw(A_NONE,     J_ALWAYS,      U_IDLE);
        endcase
        return w;
    endfunction

endpackage

[src/sfs_ram.sv]
module sfs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[src/sfs_seq.sv]
module sfs_seq
    import sfs_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_cond i_cond,
    output t_uop  o_uop
);

    logic [UPC_W-1:0] r_upc;
    logic [UPC_W-1:0] n_upc;
    t_uop             w_uop;
    logic             w_take;

    always_comb begin
        w_uop = ucode_word(r_upc);
        unique case (w_uop.jcond)
            J_NEVER:       w_take = 1'b0;
            J_ALWAYS:      w_take = 1'b1;
            J_NO_ITEM:     w_take = !i_cond.item_valid;
            J_OP_TICK:     w_take = i_cond.op_tick;
            J_OP_APPEND:   w_take = i_cond.op_append;
            J_OP_PLAY:     w_take = i_cond.op_play;
            J_OP_STOP:     w_take = i_cond.op_stop;
            J_OP_SEEK:     w_take = i_cond.op_seek;
            J_SEEK_BAD:    w_take = i_cond.seek_bad;
            J_FULL:        w_take = i_cond.full;
            J_NOT_RUNNING: w_take = !i_cond.running;
            J_HAVE_FRAMES: w_take = i_cond.have_frames;
            J_SUM_GE_FT:   w_take = i_cond.sum_ge_ft;
            J_DIV_BUSY:    w_take = i_cond.div_busy;
            J_END_NO_LOOP: w_take = i_cond.end_no_loop;
            J_OUT_BUSY:    w_take = i_cond.out_busy;
            default:       w_take = 1'b1;
        endcase
        n_upc = w_take ? w_uop.target : r_upc + UPC_W'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upc <= U_IDLE;
        end else begin
            r_upc <= n_upc;
        end
    end

    assign o_uop = w_uop;

endmodule

[src/sfs_dp.sv]
module sfs_dp
    import sfs_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_uop      i_uop,
    input  t_cfg      i_cfg,
    input  logic      i_in_valid,
    input  t_in_item  i_in_item,
    output logic      o_in_ready,
    input  logic      i_out_ready,
    output logic      o_out_valid,
    output t_out_item o_out_item,
    output t_cond     o_cond
);

    t_in_item              r_item;
    logic [CNT_W-1:0]      r_count;
    logic [IDX_W-1:0]      r_idx;
    logic                  r_ovf;
    logic [TIME_BITS-1:0]  r_accum;
    logic                  r_running;
    logic [COORD_BITS-1:0] r_shown_x;
    logic [COORD_BITS-1:0] r_shown_y;
    logic [ERR_W-1:0]      r_err;
    logic                  r_upd;
    logic [TIME_BITS:0]    r_sum;
    logic [TIME_BITS-1:0]  r_ft;
    logic [TIME_BITS-1:0]  r_rem;
    logic [TIME_BITS:0]    r_dvd;
    logic [DIV_CNT_W-1:0]  r_dcnt;
    logic                  r_out_valid;
    t_out_item             r_out;

    logic [TIME_BITS-1:0]    w_ft_eff;
    logic [TIME_BITS:0]      w_sum;
    logic [TIME_BITS:0]      w_trial;
    logic [TIME_BITS:0]      w_diff;
    logic                    w_trial_ge;
    logic [IDX_W:0]          w_next_idx;
    logic                    w_at_end;
    logic                    w_no_rect;
    logic                    w_out_busy;
    logic                    w_accept;
    logic                    w_emit;
    logic [2*COORD_BITS-1:0] w_rdata;

    sfs_ram #(
        .WIDTH(2 * COORD_BITS),
        .DEPTH(FRAME_DEPTH)
    ) u_table (
        .i_clk  (i_clk),
        .i_we   (i_uop.act == A_APPEND),
        .i_waddr(r_count[ADDR_W-1:0]),
        .i_wdata({r_item.new_x, r_item.new_y}),
        .i_raddr(r_idx[ADDR_W-1:0]),
        .o_rdata(w_rdata)
    );

    always_comb begin
        w_ft_eff   = (i_cfg.frame_time_us == '0) ? TIME_BITS'(1) : i_cfg.frame_time_us;
        w_sum      = {1'b0, r_accum} + {1'b0, r_item.elapsed_us};
        w_trial    = {r_rem, r_dvd[TIME_BITS]};
        w_diff     = w_trial - {1'b0, r_ft};
        w_trial_ge = w_trial >= {1'b0, r_ft};
        w_next_idx = {1'b0, r_idx} + (IDX_W + 1)'(1);
        w_at_end   = r_ovf || (w_next_idx >= (IDX_W + 1)'(r_count));
        w_no_rect  = r_ovf || ({1'b0, r_idx} >= (IDX_W + 1)'(FRAME_DEPTH));
        w_out_busy = r_out_valid && !i_out_ready;
        w_accept   = (i_uop.act == A_ACCEPT) && i_in_valid;
        w_emit     = (i_uop.act == A_EMIT) && !w_out_busy;

        o_cond.item_valid  = i_in_valid;
        o_cond.op_tick     = r_item.opcode == OP_TICK;
        o_cond.op_append   = r_item.opcode == OP_APPEND;
        o_cond.op_play     = r_item.opcode == OP_PLAY;
        o_cond.op_stop     = r_item.opcode == OP_STOP;
        o_cond.op_seek     = r_item.opcode == OP_SEEK;
        o_cond.seek_bad    = CNT_W'(r_item.seek_index) >= r_count;
        o_cond.full        = r_count >= CNT_W'(FRAME_DEPTH);
        o_cond.running     = r_running;
        o_cond.have_frames = r_count != '0;
        o_cond.sum_ge_ft   = r_sum >= {1'b0, r_ft};
        o_cond.div_busy    = r_dcnt != DIV_CNT_W'(TIME_BITS);
        o_cond.end_no_loop = w_at_end && !i_cfg.loop_enable;
        o_cond.out_busy    = w_out_busy;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_idx       <= '0;
            r_ovf       <= 1'b0;
            r_accum     <= '0;
            r_running   <= 1'b0;
            r_shown_x   <= '0;
            r_shown_y   <= '0;
            r_err       <= ERR_OK;
            r_upd       <= 1'b0;
            r_dcnt      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            unique case (i_uop.act)
                A_ACCEPT: begin
                    if (i_in_valid) begin
                        r_err <= ERR_OK;
                        r_upd <= 1'b0;
                    end
                end
                A_PLAY: begin
                    if (r_item.restart) begin
                        r_idx   <= '0;
                        r_ovf   <= 1'b0;
                        r_accum <= '0;
                    end
                    r_running <= 1'b1;
                end
                A_STOP: r_running <= 1'b0;
                A_SEEK: begin
                    r_idx <= IDX_W'(r_item.seek_index);
                    r_ovf <= 1'b0;
                end
                A_ERR_SEEK: r_err <= ERR_SEEK_RANGE;
                A_APPEND: r_count <= r_count + CNT_W'(1);
                A_ERR_FULL: r_err <= ERR_TABLE_FULL;
                A_ERR_NOFR: r_err <= ERR_NO_FRAMES;
                A_KEEP_SUM: r_accum <= r_sum[TIME_BITS-1:0];
                A_DIV_INIT: r_dcnt <= '0;
                A_DIV_STEP: r_dcnt <= r_dcnt + DIV_CNT_W'(1);
                A_ADVANCE: begin
                    r_accum <= r_rem;
                    if (w_at_end && i_cfg.loop_enable) begin
                        r_idx <= '0;
                        r_ovf <= 1'b0;
                    end else if (w_at_end) begin
                        r_idx     <= w_next_idx[IDX_W-1:0];
                        r_ovf     <= r_ovf || w_next_idx[IDX_W];
                        r_running <= 1'b0;
                    end else begin
                        r_idx <= w_next_idx[IDX_W-1:0];
                    end
                end
                A_SHOW: begin
                    r_shown_x <= w_no_rect ? '0 : w_rdata[2*COORD_BITS-1:COORD_BITS];
                    r_shown_y <= w_no_rect ? '0 : w_rdata[COORD_BITS-1:0];
                    r_upd     <= 1'b1;
                end
                default: begin
                end
            endcase

            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_item <= i_in_item;
        end
        if (i_uop.act == A_SUM) begin
            r_sum <= w_sum;
            r_ft  <= w_ft_eff;
        end
        if (i_uop.act == A_DIV_INIT) begin
            r_rem <= '0;
            r_dvd <= r_sum;
        end else if (i_uop.act == A_DIV_STEP) begin
            r_rem <= w_trial_ge ? w_diff[TIME_BITS-1:0] : w_trial[TIME_BITS-1:0];
            r_dvd <= {r_dvd[TIME_BITS-1:0], 1'b0};
        end
        if (w_emit) begin
            r_out.rect_x        <= r_shown_x;
            r_out.rect_y        <= r_shown_y;
            r_out.rect_w        <= i_cfg.frame_width;
            r_out.rect_h        <= i_cfg.frame_height;
            r_out.rect_updated  <= r_upd;
            r_out.current_index <= r_idx;
            r_out.is_playing    <= r_running;
            r_out.error_code    <= r_err;
        end
    end

    assign o_in_ready  = i_uop.act == A_ACCEPT;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule

[src/sprite_frame_sequencer_core.sv]
// Sprite frame sequencer core.
// Input transactions on i_in_valid/o_in_ready carry an opcode: tick with
// elapsed microseconds, append a frame position, play, stop or seek. Every
// input transaction produces exactly one output transaction on
// o_out_valid/i_out_ready that reports the displayed rectangle, the frame
// index, the playing flag and an error code.
// Configuration registers are written through i_cfg_we/i_cfg_index/i_cfg_data
// by the user only while no transaction is in flight; the block does not
// enforce this. A microcoded controller runs one input transaction at a time.
// A tick that advances a frame runs the 25-step restoring remainder loop to
// keep the time left over in the frame timer.
// The output register frees the input side: the next input transaction is
// accepted while a result waits. If the receiver stalls with a result still
// held, the controller waits before writing the following result.
// Synchronous reset clears the frame count, index, timer, playing flag and
// displayed rectangle and loads the default register values; no clearing
// pass runs over the frame table.
module sprite_frame_sequencer_core
    import sfs_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_in_item              i_in_item,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out_item             o_out_item,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg  r_cfg;
    t_uop  w_uop;
    t_cond w_cond;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.frame_time_us <= FRAME_TIME_RESET;
            r_cfg.loop_enable   <= 1'b0;
            r_cfg.frame_width   <= '0;
            r_cfg.frame_height  <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_FRAME_TIME:   r_cfg.frame_time_us <= i_cfg_data[TIME_BITS-1:0];
                CFG_LOOP_ENABLE:  r_cfg.loop_enable   <= i_cfg_data[0];
                CFG_FRAME_WIDTH:  r_cfg.frame_width   <= i_cfg_data[COORD_BITS-1:0];
                CFG_FRAME_HEIGHT: r_cfg.frame_height  <= i_cfg_data[COORD_BITS-1:0];
                default: begin
                end
            endcase
        end
    end

    sfs_seq u_seq (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_cond (w_cond),
        .o_uop  (w_uop)
    );

    sfs_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_uop      (w_uop),
        .i_cfg      (r_cfg),
        .i_in_valid (i_in_valid),
        .i_in_item  (i_in_item),
        .o_in_ready (o_in_ready),
        .i_out_ready(i_out_ready),
        .o_out_valid(o_out_valid),
        .o_out_item (o_out_item),
        .o_cond     (w_cond)
    );

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("input accepted again while a transaction is in work");

    a_error_no_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_out_item.rect_updated && (o_out_item.error_code != ERR_OK)))
        else $error("rectangle reported as updated together with an error");

    a_no_frames_running: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_item.error_code == ERR_NO_FRAMES) |-> o_out_item.is_playing)
        else $error("no-frames error reported while stopped");

endmodule

[verif/tb_top.sv]
module tb_top;
    import sfs_pkg::*;

    localparam logic [OPC_W-1:0] OP_SPARE_5 = 3'd5;
    localparam logic [OPC_W-1:0] OP_SPARE_6 = 3'd6;
    localparam logic [OPC_W-1:0] OP_SPARE_7 = 3'd7;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 40;
    localparam int HOLD_CYCLES    = 300;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  o_in_ready;
    t_in_item              in_item = '0;
    logic                  o_out_valid;
    logic                  out_ready = 1'b0;
    t_out_item             o_out_item;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = CFG_FRAME_TIME;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    sprite_frame_sequencer_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (o_out_item),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Sequencer state as the testbench expects it.
    logic [COORD_BITS-1:0] tbl_x [FRAME_DEPTH];
    logic [COORD_BITS-1:0] tbl_y [FRAME_DEPTH];
    logic [IDX_W-1:0]      n_frames = '0;
    logic [31:0]           cur_idx = '0;
    logic [TIME_BITS-1:0]  timer_us = '0;
    logic                  playing = 1'b0;
    logic [COORD_BITS-1:0] show_x = '0;
    logic [COORD_BITS-1:0] show_y = '0;
    logic [TIME_BITS-1:0]  frame_time = FRAME_TIME_RESET;
    logic                  loop_on = 1'b0;
    logic [COORD_BITS-1:0] rect_width = '0;
    logic [COORD_BITS-1:0] rect_height = '0;

    t_in_item  item_backlog [$];
    t_out_item rect_expect [$];
    bit        gaps_on = 1'b1;
    bit        stalls_on = 1'b1;
    int        gap_left = 0;
    int        stall_left = 0;
    int        results_seen = 0;
    int        mismatches = 0;
    int        quiet_cycles = 0;
    int        queued = 0;
    int        planned_frames = 0;

    function automatic void show_frame();
        if (cur_idx < 32'(FRAME_DEPTH)) begin
            show_x = tbl_x[cur_idx[ADDR_W-1:0]];
            show_y = tbl_y[cur_idx[ADDR_W-1:0]];
        end else begin
            show_x = '0;
            show_y = '0;
        end
    endfunction

    function automatic t_out_item seq_predict(input t_in_item it);
        t_out_item          r;
        logic [TIME_BITS:0] span;
        logic [TIME_BITS:0] total;
        logic [ERR_W-1:0]   err;
        logic               upd;
        err = ERR_OK;
        upd = 1'b0;
        case (it.opcode)
            OP_TICK: begin
                if (playing && n_frames == '0) begin
                    err = ERR_NO_FRAMES;
                end else if (playing) begin
                    span = (frame_time == '0) ? (TIME_BITS + 1)'(1) : {1'b0, frame_time};
                    total = {1'b0, timer_us} + {1'b0, it.elapsed_us};
                    if (total >= span) begin
                        timer_us = TIME_BITS'(total % span);
                        cur_idx = cur_idx + 32'd1;
                        if (cur_idx >= 32'(n_frames) && !loop_on) begin
                            playing = 1'b0;
                        end else begin
                            if (cur_idx >= 32'(n_frames)) begin
                                cur_idx = '0;
                            end
                            show_frame();
                            upd = 1'b1;
                        end
                    end else begin
                        timer_us = total[TIME_BITS-1:0];
                    end
                end
            end
            OP_APPEND: begin
                if (n_frames >= FRAME_DEPTH) begin
                    err = ERR_TABLE_FULL;
                end else begin
                    tbl_x[n_frames[ADDR_W-1:0]] = it.new_x;
                    tbl_y[n_frames[ADDR_W-1:0]] = it.new_y;
                    n_frames = n_frames + 1'b1;
                    show_frame();
                    upd = 1'b1;
                end
            end
            OP_PLAY: begin
                if (it.restart) begin
                    cur_idx = '0;
                    timer_us = '0;
                end
                playing = 1'b1;
            end
            OP_STOP: begin
                playing = 1'b0;
            end
            OP_SEEK: begin
                if (IDX_W'(it.seek_index) >= n_frames) begin
                    err = ERR_SEEK_RANGE;
                end else begin
                    cur_idx = 32'(it.seek_index);
                    show_frame();
                    upd = 1'b1;
                end
            end
            default: begin
            end
        endcase
        r.rect_x        = show_x;
        r.rect_y        = show_y;
        r.rect_w        = rect_width;
        r.rect_h        = rect_height;
        r.rect_updated  = upd;
        r.current_index = cur_idx[IDX_W-1:0];
        r.is_playing    = playing;
        r.error_code    = err;
        return r;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) begin
            return 0;
        end else if (r < 93) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 60);
    endfunction

    always @(posedge i_clk) begin : item_driver
        bit        busy;
        t_out_item exp_r;
        if (!i_rst_n) begin
            in_valid <= 1'b0;
            gap_left = 0;
        end else begin
            busy = in_valid;
            if (in_valid && o_in_ready) begin
                exp_r = seq_predict(in_item);
                rect_expect = {rect_expect, exp_r};
                busy = 1'b0;
                gap_left = gaps_on ? pick_gap() : 0;
            end
            if (!busy) begin
                if (gap_left > 0) begin
                    gap_left--;
                    in_valid <= 1'b0;
                end else if (item_backlog.size() > 0) begin
                    in_item <= item_backlog.pop_front();
                    in_valid <= 1'b1;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    task automatic check_field(input string fname, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("mismatch in result %0d, %s: expected %0h, got %0h",
                         results_seen, fname, want, got);
            end
        end
    endtask

    always @(posedge i_clk) begin : result_monitor
        t_out_item want;
        int        hold;
        if (!i_rst_n) begin
            out_ready <= 1'b0;
            stall_left = 0;
        end else begin
            hold = stall_left;
            if (o_out_valid && out_ready) begin
                results_seen++;
                if (rect_expect.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("result %0d arrived with nothing expected: %p",
                                 results_seen, o_out_item);
                    end
                end else begin
                    want = rect_expect.pop_front();
                    check_field("rect_x", 32'(want.rect_x), 32'(o_out_item.rect_x));
                    check_field("rect_y", 32'(want.rect_y), 32'(o_out_item.rect_y));
                    check_field("rect_w", 32'(want.rect_w), 32'(o_out_item.rect_w));
                    check_field("rect_h", 32'(want.rect_h), 32'(o_out_item.rect_h));
                    check_field("rect_updated", 32'(want.rect_updated),
                                32'(o_out_item.rect_updated));
                    check_field("current_index", 32'(want.current_index),
                                32'(o_out_item.current_index));
                    check_field("is_playing", 32'(want.is_playing),
                                32'(o_out_item.is_playing));
                    check_field("error_code", 32'(want.error_code),
                                32'(o_out_item.error_code));
                end
                if (results_seen == 150 || results_seen == 420) begin
                    hold = HOLD_CYCLES;
                end
            end
            if (hold > 0) begin
                out_ready <= 1'b0;
                stall_left = hold - 1;
            end else begin
                out_ready <= 1'b1;
                stall_left = (stalls_on && $urandom_range(0, 7) == 0) ? pick_gap() : 0;
            end
        end
    end

    always @(posedge i_clk) begin : watchdog
        if ((in_valid && o_in_ready) || (o_out_valid && out_ready) || !i_rst_n) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("status: fail");
                $finish;
            end
        end
    end

    function automatic t_in_item make_item(input logic [OPC_W-1:0] op,
                                           input logic [TIME_BITS-1:0] el,
                                           input logic [COORD_BITS-1:0] x,
                                           input logic [COORD_BITS-1:0] y,
                                           input logic rs,
                                           input logic [SEEK_W-1:0] sk);
        t_in_item it;
        it.opcode     = op;
        it.elapsed_us = el;
        it.new_x      = x;
        it.new_y      = y;
        it.restart    = rs;
        it.seek_index = sk;
        return it;
    endfunction

    function automatic t_in_item noise_item();
        return make_item(OPC_W'($urandom_range(0, 7)), TIME_BITS'($urandom),
                         COORD_BITS'($urandom), COORD_BITS'($urandom),
                         1'($urandom), SEEK_W'($urandom));
    endfunction

    task automatic queue_item(input t_in_item it);
        if (it.opcode == OP_APPEND && planned_frames < FRAME_DEPTH) begin
            planned_frames++;
        end
        item_backlog = {item_backlog, it};
        queued++;
    endtask

    task automatic queue_op(input logic [OPC_W-1:0] op, input logic [TIME_BITS-1:0] el,
                            input logic [COORD_BITS-1:0] x, input logic [COORD_BITS-1:0] y,
                            input logic rs, input logic [SEEK_W-1:0] sk);
        queue_item(make_item(op, el, x, y, rs, sk));
    endtask

    function automatic logic [TIME_BITS-1:0] pick_elapsed(input logic [TIME_BITS-1:0] ft);
        longint e;
        longint v;
        e = (ft == '0) ? 1 : ft;
        case ($urandom_range(0, 7))
            0: v = 0;
            1: v = $urandom_range(0, int'(e - 1));
            2: v = e - 1;
            3: v = e;
            4: v = e + $urandom_range(0, int'(e));
            5: v = 3 * e + $urandom_range(0, 100);
            6: v = (1 << TIME_BITS) - 1;
            default: v = TIME_BITS'($urandom);
        endcase
        if (v > (1 << TIME_BITS) - 1) begin
            v = (1 << TIME_BITS) - 1;
        end
        return TIME_BITS'(v);
    endfunction

    task automatic queue_append();
        case ($urandom_range(0, 3))
            0: queue_op(OP_APPEND, TIME_BITS'($urandom), '1, '0, 1'($urandom), SEEK_W'($urandom));
            1: queue_op(OP_APPEND, TIME_BITS'($urandom), '0, '1, 1'($urandom), SEEK_W'($urandom));
            default: queue_op(OP_APPEND, TIME_BITS'($urandom), COORD_BITS'($urandom),
                              COORD_BITS'($urandom), 1'($urandom), SEEK_W'($urandom));
        endcase
    endtask

    task automatic queue_seek();
        logic [SEEK_W-1:0] sk;
        if ($urandom_range(0, 3) == 0 || planned_frames == 0) begin
            sk = SEEK_W'($urandom);
        end else begin
            sk = SEEK_W'($urandom_range(0, planned_frames - 1));
        end
        queue_op(OP_SEEK, TIME_BITS'($urandom), COORD_BITS'($urandom),
                 COORD_BITS'($urandom), 1'($urandom), sk);
    endtask

    task automatic queue_sequence(input logic [TIME_BITS-1:0] ft);
        int kind;
        int n;
        kind = $urandom_range(0, 9);
        if (kind <= 5) begin
            queue_op(OP_PLAY, TIME_BITS'($urandom), COORD_BITS'($urandom),
                     COORD_BITS'($urandom), 1'($urandom), SEEK_W'($urandom));
            n = $urandom_range(2, 10);
            for (int k = 0; k < n; k++) begin
                if ($urandom_range(0, 11) == 0) begin
                    queue_seek();
                end
                queue_op(OP_TICK, pick_elapsed(ft), COORD_BITS'($urandom),
                         COORD_BITS'($urandom), 1'($urandom), SEEK_W'($urandom));
            end
            if ($urandom_range(0, 1) == 1) begin
                queue_op(OP_STOP, TIME_BITS'($urandom), COORD_BITS'($urandom),
                         COORD_BITS'($urandom), 1'($urandom), SEEK_W'($urandom));
            end
        end else if (kind <= 7) begin
            n = $urandom_range(1, 3);
            for (int k = 0; k < n; k++) begin
                queue_append();
            end
        end else if (kind == 8) begin
            queue_seek();
            queue_seek();
        end else begin
            n = $urandom_range(2, 4);
            for (int k = 0; k < n; k++) begin
                queue_item(noise_item());
            end
        end
    endtask

    task automatic settle();
        while (item_backlog.size() != 0 || in_valid || rect_expect.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        case (idx)
            CFG_FRAME_TIME:   frame_time = val[TIME_BITS-1:0];
            CFG_LOOP_ENABLE:  loop_on = val[0];
            CFG_FRAME_WIDTH:  rect_width = val[COORD_BITS-1:0];
            CFG_FRAME_HEIGHT: rect_height = val[COORD_BITS-1:0];
            default: begin
            end
        endcase
        @(posedge i_clk);
    endtask

    task automatic run_phase(input logic [TIME_BITS-1:0] ft, input logic lp,
                             input logic [COORD_BITS-1:0] w, input logic [COORD_BITS-1:0] h,
                             input bit idle, input int n_items, input bit fill);
        int start;
        settle();
        write_reg(CFG_FRAME_TIME, CFG_DATA_W'(ft));
        write_reg(CFG_LOOP_ENABLE, CFG_DATA_W'(lp));
        write_reg(CFG_FRAME_WIDTH, CFG_DATA_W'(w));
        write_reg(CFG_FRAME_HEIGHT, CFG_DATA_W'(h));
        cfg_we <= 1'b0;
        gaps_on = idle;
        stalls_on = idle;
        start = queued;
        if (fill) begin
            while (planned_frames < FRAME_DEPTH) begin
                queue_append();
            end
            queue_append();
            queue_append();
            queue_op(OP_SEEK, '0, '0, '0, 1'b0, SEEK_W'(FRAME_DEPTH - 1));
        end
        while (queued - start < n_items) begin
            queue_sequence(ft);
        end
    endtask

    initial begin
        queue_op(OP_TICK, '1, '0, '0, 1'b0, '0);
        queue_op(OP_SEEK, '0, '0, '0, 1'b0, '0);
        queue_op(OP_PLAY, '0, '0, '0, 1'b0, '0);
        queue_op(OP_TICK, '1, '1, '1, 1'b1, '1);
        queue_op(OP_SPARE_5, '1, '1, '1, 1'b1, '1);
        queue_op(OP_SPARE_6, '0, '0, '0, 1'b0, '0);
        queue_op(OP_SPARE_7, TIME_BITS'($urandom), COORD_BITS'($urandom),
                 COORD_BITS'($urandom), 1'b1, SEEK_W'($urandom));
        queue_op(OP_STOP, '0, '0, '0, 1'b0, '0);
        queue_op(OP_APPEND, '0, '1, '1, 1'b0, '0);
        queue_op(OP_APPEND, '1, '0, '0, 1'b1, '1);
        queue_op(OP_APPEND, '0, COORD_BITS'($urandom), COORD_BITS'($urandom), 1'b0, '0);
        queue_op(OP_SEEK, '0, '0, '0, 1'b0, '1);
        queue_op(OP_SEEK, '0, '0, '0, 1'b0, SEEK_W'(2));
        queue_op(OP_PLAY, '0, '0, '0, 1'b1, '0);
        queue_op(OP_TICK, '0, '0, '0, 1'b0, '0);
        queue_op(OP_TICK, '1, '0, '0, 1'b0, '0);
        queue_op(OP_TICK, TIME_BITS'(99999), '0, '0, 1'b0, '0);
        queue_op(OP_TICK, TIME_BITS'(100000), '0, '0, 1'b0, '0);
        queue_op(OP_TICK, TIME_BITS'(100000), '0, '0, 1'b0, '0);
        queue_op(OP_APPEND, '0, COORD_BITS'($urandom), COORD_BITS'($urandom), 1'b0, '0);
        queue_op(OP_PLAY, '0, '0, '0, 1'b0, '0);
        queue_op(OP_TICK, TIME_BITS'(100000), '0, '0, 1'b0, '0);
        queue_op(OP_STOP, '0, '0, '0, 1'b0, '0);

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        run_phase(TIME_BITS'(1), 1'b1, '1, '0, 1'b1, 85, 1'b0);
        run_phase('0, 1'b0, '0, '1, 1'b0, 85, 1'b0);
        run_phase('1, 1'b1, COORD_BITS'($urandom), COORD_BITS'($urandom), 1'b1, 85, 1'b0);
        run_phase(TIME_BITS'($urandom_range(1, 5000)), 1'b0, COORD_BITS'($urandom),
                  COORD_BITS'($urandom), 1'b1, 85, 1'b0);
        run_phase(TIME_BITS'(1000), 1'b1, '1, '1, 1'b1, 85, 1'b1);
        run_phase(TIME_BITS'($urandom_range(1, (1 << TIME_BITS) - 1)), 1'($urandom),
                  COORD_BITS'($urandom), COORD_BITS'($urandom), 1'b1, 85, 1'b0);
        settle();

        if (mismatches == 0 && rect_expect.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
